### src/cfa_pkg.sv
// ----------------------------------------------------------------------------
// Continued fraction approximator package
// Shared widths, configuration codes and the item record that travels
// down the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cfa_pkg;

    // Fixed-point format of the input value.
    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned FRAC_BITS = 16;

    // Configuration register widths and reset values.
    localparam int unsigned MT_W  = 4;
    localparam int unsigned TOL_W = 16;
    localparam logic [MT_W-1:0]  MAX_TERMS_RST = MT_W'(10);
    localparam logic [TOL_W-1:0] TOLERANCE_RST = TOL_W'(33);
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = TOL_W;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TERMS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = CFG_IDX_W'(1);

    // One Euclid step per stage group, as many as max_terms can ask for.
    localparam int unsigned STEPS = (1 << MT_W) - 1;

    // Remainder, divisor and quotient widths.
    localparam int unsigned R_W = FRAC_BITS;
    localparam int unsigned D_W = FRAC_BITS + 1;
    // Convergent widths: h/k stays below the integer part plus one.
    localparam int unsigned H_W = VALUE_W + 1;
    localparam int unsigned K_W = FRAC_BITS + 1;
    // Width of the stop-threshold compare.
    localparam int unsigned CMP_W = (TOL_W + D_W > 2 * FRAC_BITS) ?
                                    (TOL_W + D_W) : (2 * FRAC_BITS);

    // Result field widths.
    localparam int unsigned NUM_W = 48;
    localparam int unsigned DEN_W = 17;

    // Working state of one item.
    typedef struct packed {
        logic           neg;
        logic           done;
        logic [R_W-1:0] r;
        logic [D_W-1:0] d;
        logic [H_W-1:0] h1;
        logic [H_W-1:0] h0;
        logic [K_W-1:0] k1;
        logic [K_W-1:0] k0;
    } t_item;

endpackage

`default_nettype wire

### src/cfa_front.sv
// ----------------------------------------------------------------------------
// Continued fraction front stage
// Splits off the sign and seeds the convergents with the integer part.
// ----------------------------------------------------------------------------
`default_nettype none

module cfa_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic [cfa_pkg::VALUE_W-1:0]  i_value_q,
    output logic                              o_valid,
    output cfa_pkg::t_item                    o_item
);
    import cfa_pkg::*;

    logic               neg;
    logic [VALUE_W-1:0] mag;
    t_item              n_item;
    logic               r_valid;
    t_item              r_item;

    // Magnitude; the most negative value maps onto 2^31 as unsigned.
    always_comb begin
        neg = i_value_q[VALUE_W-1];
        mag = neg ? (VALUE_W'(0) - i_value_q) : i_value_q;
        n_item      = '0;
        n_item.neg  = neg;
        n_item.done = 1'b0;
        n_item.r    = mag[FRAC_BITS-1:0];
        n_item.d    = D_W'(1) << FRAC_BITS;
        n_item.h1   = H_W'(mag[VALUE_W-1:FRAC_BITS]);
        n_item.h0   = H_W'(1);
        n_item.k1   = K_W'(1);
        n_item.k0   = '0;
    end

    // Entry register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

### src/cfa_step.sv
// ----------------------------------------------------------------------------
// Continued fraction Euclid step
// One partial quotient: stop decision, a pipelined restoring division with
// one quotient bit per stage, then the convergent update.
// ----------------------------------------------------------------------------
`default_nettype none

module cfa_step #(
    parameter int unsigned IDX = 0
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic [cfa_pkg::MT_W-1:0]   i_max_terms,
    input  wire logic [cfa_pkg::TOL_W-1:0]  i_tolerance,
    input  wire logic                       i_valid,
    input  wire cfa_pkg::t_item             i_item,
    output logic                            o_valid,
    output cfa_pkg::t_item                  o_item
);
    import cfa_pkg::*;

    localparam logic [MT_W-1:0] STEP_IDX = MT_W'(IDX);

    // ---- Stop decision ----
    logic [CMP_W-1:0] lhs;
    logic [CMP_W-1:0] rhs;
    logic             go;
    t_item            n_a_item;
    logic             r_a_valid;
    t_item            r_a_item;

    // Continue while the remaining fraction is above the tolerance.
    always_comb begin
        lhs = CMP_W'({i_item.r, {FRAC_BITS{1'b0}}});
        rhs = CMP_W'(i_tolerance) * CMP_W'(i_item.d);
        go  = !i_item.done && (STEP_IDX < i_max_terms) &&
              (i_item.r != '0) && (lhs > rhs);
        n_a_item      = i_item;
        n_a_item.done = !go;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
        if (i_en) begin
            r_a_item <= n_a_item;
        end
    end

    // ---- Division pipeline: d / r, one quotient bit per stage ----
    logic           w_vld  [0:D_W];
    t_item          w_item [0:D_W];
    logic [R_W-1:0] w_rem  [0:D_W];
    logic [D_W-1:0] w_q    [0:D_W];

    assign w_vld[0]  = r_a_valid;
    assign w_item[0] = r_a_item;
    assign w_rem[0]  = '0;
    assign w_q[0]    = '0;

    for (genvar j = 0; j < D_W; j++) begin : g_div
        logic           r_vld;
        t_item          r_item;
        logic [R_W-1:0] r_rem;
        logic [D_W-1:0] r_q;
        logic [R_W:0]   trial;
        logic           ge;
        logic [R_W:0]   diff;

        // Shift in the next dividend bit and try to subtract the divisor.
        always_comb begin
            trial = {w_rem[j], w_item[j].d[D_W-1-j]};
            ge    = trial >= {1'b0, w_item[j].r};
            diff  = ge ? (trial - {1'b0, w_item[j].r}) : trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[j];
            end
            if (i_en) begin
                r_item <= w_item[j];
                r_rem  <= diff[R_W-1:0];
                r_q    <= {w_q[j][D_W-2:0], ge};
            end
        end

        assign w_vld[j+1]  = r_vld;
        assign w_item[j+1] = r_item;
        assign w_rem[j+1]  = r_rem;
        assign w_q[j+1]    = r_q;
    end

    // ---- Convergent update ----
    logic [D_W+H_W-1:0] ph;
    logic [D_W+K_W-1:0] pk;
    t_item              upd;
    logic               r_o_valid;
    t_item              r_o_item;

    // h = a*h1 + h0, k = a*k1 + k0, then (r, d) = (d mod r, r).
    always_comb begin
        ph  = (D_W+H_W)'(w_q[D_W]) * (D_W+H_W)'(w_item[D_W].h1);
        pk  = (D_W+K_W)'(w_q[D_W]) * (D_W+K_W)'(w_item[D_W].k1);
        upd = w_item[D_W];
        if (!w_item[D_W].done) begin
            upd.h1 = H_W'(ph + (D_W+H_W)'(w_item[D_W].h0));
            upd.k1 = K_W'(pk + (D_W+K_W)'(w_item[D_W].k0));
            upd.h0 = w_item[D_W].h1;
            upd.k0 = w_item[D_W].k1;
            upd.d  = D_W'(w_item[D_W].r);
            upd.r  = w_rem[D_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_o_valid <= w_vld[D_W];
        end
        if (i_en) begin
            r_o_item <= upd;
        end
    end

    assign o_valid = r_o_valid;
    assign o_item  = r_o_item;

endmodule

`default_nettype wire

### src/cfa_back.sv
// ----------------------------------------------------------------------------
// Continued fraction back stage
// Applies the sign to the last convergent and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module cfa_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire cfa_pkg::t_item             i_item,
    output logic                            o_valid,
    output logic signed [cfa_pkg::NUM_W-1:0] o_numerator,
    output logic [cfa_pkg::DEN_W-1:0]       o_denominator,
    output logic                            o_is_whole
);
    import cfa_pkg::*;

    logic [NUM_W-1:0] mag;
    logic             r_valid;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic             r_whole;

    assign mag = NUM_W'(i_item.h1);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_num   <= i_item.neg ? (NUM_W'(0) - mag) : mag;
            r_den   <= DEN_W'(i_item.k1);
            r_whole <= (i_item.k1 == K_W'(1));
        end
    end

    assign o_valid       = r_valid;
    assign o_numerator   = r_num;
    assign o_denominator = r_den;
    assign o_is_whole    = r_whole;

endmodule

`default_nettype wire

### src/continued_fraction_approximator.sv
// Pipeline: entry register, 15 Euclid steps of 19 stages each, output register.
// Throughput: one item per cycle; the whole pipeline holds while a result
// beat waits at a stalled output.
// Reset: synchronous, active low; clears all valid bits and sets max_terms
// to 10 and tolerance to 33.
// ----------------------------------------------------------------------------
// Continued fraction approximator
// Rational approximation h/k of a signed fixed-point value by convergents.
// ----------------------------------------------------------------------------
`default_nettype none

module continued_fraction_approximator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [cfa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [cfa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic signed [cfa_pkg::VALUE_W-1:0] i_value_q,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic signed [cfa_pkg::NUM_W-1:0]     o_numerator,
    output logic [cfa_pkg::DEN_W-1:0]            o_denominator,
    output logic                                 o_is_whole
);
    import cfa_pkg::*;

    logic [MT_W-1:0]  r_mt;
    logic [TOL_W-1:0] r_tolerance;
    logic             en;
    logic             v     [0:STEPS];
    t_item            item  [0:STEPS];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mt        <= MAX_TERMS_RST;
            r_tolerance <= TOLERANCE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_TERMS: r_mt        <= i_cfg_data[MT_W-1:0];
                CFG_TOLERANCE: r_tolerance <= i_cfg_data[TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The pipeline moves unless a result beat is held at the output.
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    cfa_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_value_q (i_value_q),
        .o_valid   (v[0]),
        .o_item    (item[0])
    );

    // One stage group per Euclid step.
    for (genvar s = 0; s < STEPS; s++) begin : g_step
        cfa_step #(
            .IDX (s)
        ) u_step (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (en),
            .i_max_terms (r_mt),
            .i_tolerance (r_tolerance),
            .i_valid     (v[s]),
            .i_item      (item[s]),
            .o_valid     (v[s+1]),
            .o_item      (item[s+1])
        );
    end

    cfa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (v[STEPS]),
        .i_item        (item[STEPS]),
        .o_valid       (o_valid),
        .o_numerator   (o_numerator),
        .o_denominator (o_denominator),
        .o_is_whole    (o_is_whole)
    );

endmodule

`default_nettype wire
